// ===== rtl/iida_pkg.sv =====
`default_nettype none
package iida_pkg;

  // array geometry
  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  // transaction field widths
  localparam int KIND_BITS   = 3;
  localparam int POS_BITS    = 9;
  localparam int STATUS_BITS = 2;

  // request codes
  localparam logic [KIND_BITS-1:0] REQ_APPEND      = 3'd0;
  localparam logic [KIND_BITS-1:0] REQ_REMOVE_LAST = 3'd1;
  localparam logic [KIND_BITS-1:0] REQ_INSERT      = 3'd2;
  localparam logic [KIND_BITS-1:0] REQ_DELETE      = 3'd3;
  localparam logic [KIND_BITS-1:0] REQ_READ        = 3'd4;
  localparam logic [KIND_BITS-1:0] REQ_WRITE       = 3'd5;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic latch;     // capture the request transaction
    logic rd_pos;    // read the entry at position
    logic up_start;  // begin shifting entries up from the last one
    logic up_step;   // move one entry up, fetch the next lower one
    logic dn_start;  // begin shifting entries down from position
    logic dn_step;   // move one entry down, fetch the next higher one
    logic finish;    // apply the request and load the result
  } iida_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;   // result register free by the next edge
    logic need_read;
    logic need_up;
    logic need_dn;
    logic last_up;
    logic last_dn;
  } iida_sts_t;

endpackage
`default_nettype wire

// ===== rtl/iida_if.sv =====
`default_nettype none
// request channel
interface iida_req_if;
  import iida_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] req_type;
  logic [POS_BITS-1:0]  position;
  logic [WORD_BITS-1:0] write_value;

  modport source (output valid, output req_type, output position, output write_value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input write_value,
                  output ready);
endinterface

// result channel
interface iida_rsp_if;
  import iida_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [WORD_BITS-1:0]   read_value;
  logic [STATUS_BITS-1:0] status;
  logic [CNT_BITS-1:0]    entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/indexed_insert_delete_array_core.sv =====
// Ordered word array with append, remove last, insert at, delete at,
// read and write requests, holding up to DEPTH words and a count.
// req carries one request transaction (req_type, position, write_value);
// rsp returns exactly one result per request (read_value, status,
// entry_count), in request order.
// One request is in work at a time. A request is taken while the block
// is idle and the result register is empty or being emptied that cycle.
// Append, remove last, write, errors, unused codes and an insert or
// delete that moves nothing finish straight from the execute state. A
// read first fetches the entry from the RAM. An insert that moves
// entries first shifts count - position entries up, and a delete that
// moves entries first shifts count - position - 1 entries down; the
// shift moves one entry per cycle through the single-write,
// registered-read entry RAM. The next request can be taken in the cycle
// after the result is loaded.
// Reset clears the count and the result valid flag; entry contents are
// not cleared and no clearing pass runs. A stalled receiver holds the
// result steady and blocks new requests until it is taken.
`default_nettype none
module indexed_insert_delete_array_core (
  input  wire logic clk,
  input  wire logic rst,
  iida_req_if.sink  req,
  iida_rsp_if.source rsp
);
  import iida_pkg::*;

  iida_cmd_t cmd;
  iida_sts_t sts;

  iida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iida_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (req.req_type),
    .in_position     (req.position),
    .in_write_value  (req.write_value),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_read_value  (rsp.read_value),
    .out_status      (rsp.status),
    .out_entry_count (rsp.entry_count)
  );

endmodule
`default_nettype wire

// ===== rtl/iida_ram.sv =====
`default_nettype none
module iida_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/iida_datapath.sv =====
`default_nettype none
module iida_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire iida_pkg::iida_cmd_t              cmd,
  output iida_pkg::iida_sts_t                   sts,
  input  wire logic [iida_pkg::KIND_BITS-1:0]   in_req_type,
  input  wire logic [iida_pkg::POS_BITS-1:0]    in_position,
  input  wire logic [iida_pkg::WORD_BITS-1:0]   in_write_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [iida_pkg::WORD_BITS-1:0]   out_read_value,
  output logic      [iida_pkg::STATUS_BITS-1:0] out_status,
  output logic      [iida_pkg::CNT_BITS-1:0]    out_entry_count
);
  import iida_pkg::*;

  logic [KIND_BITS-1:0]   kind;
  logic [POS_BITS-1:0]    pos;
  logic [WORD_BITS-1:0]   val;
  logic [CNT_BITS-1:0]    count;
  logic [CNT_BITS-1:0]    count_next;
  logic [ADDR_BITS-1:0]   ptr;
  logic [STATUS_BITS-1:0] code;
  logic                   ok;
  logic                   ram_we;
  logic [ADDR_BITS-1:0]   ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic [ADDR_BITS-1:0]   ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;
  logic [CNT_BITS-1:0]    pos_ext;
  logic [ADDR_BITS-1:0]   pos_addr;
  logic [ADDR_BITS-1:0]   cnt_addr;

  // position fits the count width; once checked it fits an address
  assign pos_ext  = CNT_BITS'(pos);
  assign pos_addr = pos[ADDR_BITS-1:0];
  assign cnt_addr = count[ADDR_BITS-1:0];

  // request checks against the current count
  always_comb begin
    code = ST_OK;
    unique case (kind)
      REQ_APPEND: begin
        if (count == CNT_BITS'(DEPTH)) code = ST_FULL;
      end
      REQ_REMOVE_LAST: begin
        if (count == '0) code = ST_EMPTY;
      end
      REQ_INSERT: begin
        priority if (pos_ext > count)            code = ST_RANGE;
        else if (count == CNT_BITS'(DEPTH))      code = ST_FULL;
        else                                     code = ST_OK;
      end
      REQ_DELETE, REQ_READ, REQ_WRITE: begin
        if (pos_ext >= count) code = ST_RANGE;
      end
      default: code = ST_OK;
    endcase
  end

  assign ok = (code == ST_OK);

  // status towards the controller
  always_comb begin
    sts.out_free  = !out_valid || out_ready;
    sts.need_read = ok && (kind == REQ_READ);
    sts.need_up   = ok && (kind == REQ_INSERT) && (pos_ext != count);
    sts.need_dn   = ok && (kind == REQ_DELETE) && ((pos_ext + CNT_BITS'(1)) != count);
    sts.last_up   = (ptr == pos_addr);
    sts.last_dn   = ((CNT_BITS'(ptr) + CNT_BITS'(2)) == count);
  end

  // read address selection
  always_comb begin
    priority if (cmd.up_start) ram_raddr = cnt_addr - ADDR_BITS'(1);
    else if (cmd.up_step)      ram_raddr = ptr - ADDR_BITS'(1);
    else if (cmd.dn_start)     ram_raddr = pos_addr + ADDR_BITS'(1);
    else if (cmd.dn_step)      ram_raddr = ptr + ADDR_BITS'(2);
    else if (cmd.rd_pos)       ram_raddr = pos_addr;
    else                       ram_raddr = pos_addr;
  end

  // write port: shifted entries or the stored word
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_addr;
    ram_wdata = val;
    priority if (cmd.up_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr + ADDR_BITS'(1);
      ram_wdata = ram_rdata;
    end else if (cmd.dn_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr;
      ram_wdata = ram_rdata;
    end else if (cmd.finish && ok) begin
      ram_we    = (kind == REQ_APPEND) || (kind == REQ_INSERT) || (kind == REQ_WRITE);
      ram_waddr = (kind == REQ_APPEND) ? cnt_addr : pos_addr;
      ram_wdata = val;
    end else begin
      ram_we    = 1'b0;
    end
  end

  // count after the request
  always_comb begin
    count_next = count;
    if (ok) begin
      unique case (kind)
        REQ_APPEND, REQ_INSERT:      count_next = count + CNT_BITS'(1);
        REQ_REMOVE_LAST, REQ_DELETE: count_next = count - CNT_BITS'(1);
        default:                     count_next = count;
      endcase
    end
  end

  iida_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request capture and shift pointer
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind <= in_req_type;
      pos  <= in_position;
      val  <= in_write_value;
    end
    priority if (cmd.up_start) ptr <= cnt_addr - ADDR_BITS'(1);
    else if (cmd.up_step)      ptr <= ptr - ADDR_BITS'(1);
    else if (cmd.dn_start)     ptr <= pos_addr;
    else if (cmd.dn_step)      ptr <= ptr + ADDR_BITS'(1);
    else                       ptr <= ptr;
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_read_value  <= (ok && (kind == REQ_READ)) ? ram_rdata : '0;
      out_status      <= code;
      out_entry_count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/iida_ctrl.sv =====
`default_nettype none
module iida_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire iida_pkg::iida_sts_t sts,
  output iida_pkg::iida_cmd_t      cmd
);
  import iida_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // take a transaction only once the result register is free
  assign in_ready = (state == S_IDLE) && sts.out_free;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (sts.need_read) begin
          cmd.rd_pos = 1'b1;
          state_next = S_FINISH;
        end else if (sts.need_up) begin
          cmd.up_start = 1'b1;
          state_next   = S_SHIFT_UP;
        end else if (sts.need_dn) begin
          cmd.dn_start = 1'b1;
          state_next   = S_SHIFT_DN;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SHIFT_UP: begin
        cmd.up_step = 1'b1;
        if (sts.last_up) state_next = S_FINISH;
      end
      S_SHIFT_DN: begin
        cmd.dn_step = 1'b1;
        if (sts.last_dn) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
module tb;
  import iida_pkg::*;

  // request codes with no defined operation
  localparam logic [KIND_BITS-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [KIND_BITS-1:0] REQ_SPARE_B = 3'd7;

  // a full-length shift plus result stall margin
  localparam int TAIL_CYCLES = DEPTH + 40;
  localparam int RUN_LIMIT   = 4000000;
  localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [WORD_BITS-1:0]   read_value;
    logic [STATUS_BITS-1:0] status;
    logic [CNT_BITS-1:0]    entry_count;
  } array_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  iida_req_if req ();
  iida_rsp_if rsp ();

  indexed_insert_delete_array_core dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // shadow copy of the array
  logic [WORD_BITS-1:0] shadow_entries [DEPTH];
  int                   shadow_count;

  array_result_t pending_results [$];
  int            mismatch_count;
  bit            req_gaps_on;
  bit            rsp_stalls_on;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop
  initial begin
    #RUN_LIMIT;
    $display("FAIL indexed_insert_delete_array_core");
    $finish;
  end

  // apply one request to the shadow array and work out its result
  function automatic array_result_t apply_array_request(input logic [KIND_BITS-1:0] kind,
                                                        input logic [POS_BITS-1:0] pos,
                                                        input logic [WORD_BITS-1:0] val);
    array_result_t res;
    int            at;
    at = int'(pos);
    res.read_value = '0;
    res.status     = ST_OK;
    case (kind)
      REQ_APPEND: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
        end
      end
      REQ_REMOVE_LAST: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else shadow_count--;
      end
      REQ_INSERT: begin
        // index checked before capacity
        if (at > shadow_count) begin
          res.status = ST_RANGE;
        end else if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[at] = val;
          shadow_count++;
        end
      end
      REQ_DELETE: begin
        if (at >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = at; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      REQ_READ: begin
        if (at >= shadow_count) res.status = ST_RANGE;
        else res.read_value = shadow_entries[at];
      end
      REQ_WRITE: begin
        if (at >= shadow_count) res.status = ST_RANGE;
        else shadow_entries[at] = val;
      end
      default: begin
        // spare codes leave everything alone
      end
    endcase
    res.entry_count = CNT_BITS'(shadow_count);
    return res;
  endfunction

  function automatic logic [WORD_BITS-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // present one request transaction, predict it once accepted
  task automatic send_request(input logic [KIND_BITS-1:0] kind,
                              input logic [POS_BITS-1:0] pos,
                              input logic [WORD_BITS-1:0] val);
    array_result_t predicted;
    @(negedge clk);
    if (req_gaps_on && $urandom_range(0, 3) == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    req.valid       = 1'b1;
    req.req_type    = kind;
    req.position    = pos;
    req.write_value = val;
    do @(posedge clk); while (!req.ready);
    predicted       = apply_array_request(kind, pos, val);
    pending_results = {pending_results, predicted};
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_results_drained();
    @(negedge clk);
    req.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // random request, biased towards growing or shrinking the array
  task automatic send_random_request(input bit grow);
    logic [KIND_BITS-1:0] kind;
    logic [POS_BITS-1:0]  pos;
    int                   pick;
    int                   limit;
    pick = $urandom_range(0, 99);
    if (grow) begin
      if      (pick < 30) kind = REQ_APPEND;
      else if (pick < 55) kind = REQ_INSERT;
      else if (pick < 60) kind = REQ_REMOVE_LAST;
      else if (pick < 70) kind = REQ_DELETE;
      else if (pick < 83) kind = REQ_READ;
      else if (pick < 95) kind = REQ_WRITE;
      else kind = (pick & 1) ? REQ_SPARE_A : REQ_SPARE_B;
    end else begin
      if      (pick < 5)  kind = REQ_APPEND;
      else if (pick < 15) kind = REQ_INSERT;
      else if (pick < 40) kind = REQ_REMOVE_LAST;
      else if (pick < 70) kind = REQ_DELETE;
      else if (pick < 83) kind = REQ_READ;
      else if (pick < 95) kind = REQ_WRITE;
      else kind = (pick & 1) ? REQ_SPARE_A : REQ_SPARE_B;
    end
    // mostly legal indices, some on the boundary, some anywhere
    limit = (kind == REQ_INSERT) ? shadow_count : shadow_count - 1;
    pick  = $urandom_range(0, 9);
    if (pick < 7 && limit >= 0) pos = POS_BITS'($urandom_range(0, limit));
    else if (pick == 7)         pos = POS_BITS'(shadow_count);
    else                        pos = POS_BITS'($urandom_range(0, 511));
    send_request(kind, pos, random_word());
  endtask

  // requests on an empty array
  task automatic test_empty_array();
    send_request(REQ_REMOVE_LAST, '0, '0);
    send_request(REQ_DELETE, '0, '0);
    send_request(REQ_READ, '0, '0);
    send_request(REQ_WRITE, '0, ALL_ONES);
    send_request(REQ_INSERT, 9'd1, ALL_ONES);
    send_request(REQ_READ, 9'd511, '0);
    send_request(REQ_SPARE_A, 9'd511, ALL_ONES);
    send_request(REQ_SPARE_B, 9'd0, '0);
  endtask

  // every operation on a short array, including both ends
  task automatic test_each_operation();
    send_request(REQ_APPEND, '0, '0);
    send_request(REQ_APPEND, 9'd511, ALL_ONES);
    send_request(REQ_INSERT, 9'd0, 32'h1234_5678);
    send_request(REQ_INSERT, 9'd3, 32'h8765_4321);
    send_request(REQ_INSERT, 9'd2, 32'hA5A5_5A5A);
    send_request(REQ_READ, 9'd0, '0);
    send_request(REQ_READ, 9'd4, '0);
    send_request(REQ_READ, 9'd5, '0);
    send_request(REQ_WRITE, 9'd1, 32'hDEAD_BEEF);
    send_request(REQ_WRITE, 9'd5, 32'hDEAD_BEEF);
    send_request(REQ_INSERT, 9'd7, '0);
    send_request(REQ_DELETE, 9'd2, '0);
    send_request(REQ_DELETE, 9'd3, '0);
    send_request(REQ_DELETE, 9'd0, '0);
    send_request(REQ_DELETE, 9'd2, '0);
    send_request(REQ_READ, 9'd1, '0);
    send_request(REQ_REMOVE_LAST, '0, '0);
    send_request(REQ_REMOVE_LAST, '0, '0);
    wait_results_drained();
  endtask

  // fill to capacity and probe the full cases
  task automatic test_full_array();
    while (shadow_count < DEPTH) send_request(REQ_APPEND, POS_BITS'($urandom), random_word());
    send_request(REQ_APPEND, '0, ALL_ONES);
    send_request(REQ_INSERT, 9'd0, ALL_ONES);
    send_request(REQ_INSERT, 9'd256, ALL_ONES);
    send_request(REQ_INSERT, 9'd257, ALL_ONES);
    send_request(REQ_READ, 9'd255, '0);
    send_request(REQ_READ, 9'd256, '0);
    send_request(REQ_WRITE, 9'd255, ALL_ONES);
    send_request(REQ_READ, 9'd0, '0);
    send_request(REQ_DELETE, 9'd0, '0);
    send_request(REQ_INSERT, 9'd0, 32'h0F0F_F0F0);
    send_request(REQ_READ, 9'd0, '0);
    send_request(REQ_DELETE, 9'd255, '0);
    wait_results_drained();
  endtask

  // long random mix, switching between growth and shrinkage
  task automatic test_random_mix();
    bit grow;
    grow = 1'b1;
    for (int chunk = 0; chunk < 17; chunk++) begin
      req_gaps_on   = ($urandom_range(0, 3) != 0);
      rsp_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) grow = !grow;
      for (int n = 0; n < 50; n++) begin
        if (shadow_count >= DEPTH - 8) grow = 1'b0;
        else if (shadow_count <= 4) grow = 1'b1;
        send_random_request(grow);
      end
      if (chunk == 8) wait_results_drained();
    end
    wait_results_drained();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_back_to_back();
    req_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    for (int n = 0; n < 150; n++) send_random_request(1'($urandom_range(0, 1)));
  endtask

  // result side back-pressure
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    array_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_value %h status %0d entry_count %0d",
               rsp.read_value, rsp.status, rsp.entry_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.read_value !== want.read_value) begin
          $error("read_value: expected %h, actual %h", want.read_value, rsp.read_value);
          mismatch_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, rsp.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // test sequence
  initial begin
    req.valid       = 1'b0;
    req.req_type    = '0;
    req.position    = '0;
    req.write_value = '0;
    shadow_count    = 0;
    mismatch_count  = 0;
    req_gaps_on     = 1'b1;
    rsp_stalls_on   = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_array();
    test_each_operation();
    test_full_array();
    test_random_mix();
    test_back_to_back();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS indexed_insert_delete_array_core");
    end else begin
      $display("FAIL indexed_insert_delete_array_core");
    end
    $finish;
  end

endmodule
`default_nettype wire
